>>> rtl/core/lidar_angle_group_sample_picker_defines.svh
// assertion macros used by the checker
`ifndef LIDAR_ANGLE_GROUP_SAMPLE_PICKER_DEFINES_SVH
`define LIDAR_ANGLE_GROUP_SAMPLE_PICKER_DEFINES_SVH

// same-cycle implication
`define LAGSP_ASSERT_IMPL(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("lagsp check failed");

// next-cycle implication
`define LAGSP_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("lagsp check failed");

`endif

>>> rtl/core/lagsp_pkg.sv
`default_nettype none

package lagsp_pkg;

    localparam int NUM_GROUPS      = 4;
    localparam int ANGLES_PER_SCAN = 360;
    localparam int SUPPORT_ANGLES  = 2;
    localparam int NUM_SLOTS       = 1 + 2 * (SUPPORT_ANGLES / 2);

    localparam int ANGLE_W     = 9;
    localparam int DIST_W      = 16;
    localparam int GROUP_W     = $clog2(NUM_GROUPS);
    localparam int RANK_W      = $clog2(NUM_SLOTS);
    localparam int COUNT_W     = $clog2(NUM_GROUPS + 1);
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int CMD_QUEUE_DEPTH = 2;

    localparam logic [ANGLE_W:0]  SCAN_N         = (ANGLE_W + 1)'(ANGLES_PER_SCAN);
    localparam logic [DIST_W-1:0] MIN_DIST_RESET = DIST_W'(16);

    typedef logic [ANGLE_W-1:0] t_angle;
    typedef logic [DIST_W-1:0]  t_dist;
    typedef logic [GROUP_W-1:0] t_group;
    typedef logic [RANK_W-1:0]  t_rank;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GROUP_ENABLE = 3'd0,
        REG_MAIN_ANGLE_0 = 3'd1,
        REG_MAIN_ANGLE_1 = 3'd2,
        REG_MAIN_ANGLE_2 = 3'd3,
        REG_MAIN_ANGLE_3 = 3'd4,
        REG_MIN_DISTANCE = 3'd5
    } t_reg_index;

    typedef struct packed {
        logic [NUM_GROUPS-1:0]     group_enable;
        t_angle [NUM_GROUPS-1:0]   main_angle;
        t_dist                     min_distance;
    } t_cfg;

    typedef enum logic {
        CMD_FILL,
        CMD_FLUSH
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        t_group    group;
        t_rank     rank;
        logic      dist_ok;
        t_dist     distance;
    } t_cmd;

    function automatic t_angle main_of(t_angle a);
        logic [ANGLE_W:0] w;
        w = {1'b0, a};
        if (w >= SCAN_N) begin
            w = w - SCAN_N;
        end
        return w[ANGLE_W-1:0];
    endfunction

    // rank 0 is the main angle, odd ranks step back, even ranks step forward
    function automatic t_angle angle_of_rank(t_angle m, t_rank r);
        logic [ANGLE_W:0] k;
        logic [ANGLE_W:0] sum;
        k = ((ANGLE_W + 1)'(r) + (ANGLE_W + 1)'(r[0])) >> 1;
        if (r[0]) begin
            sum = {1'b0, m} + SCAN_N - k;
        end else begin
            sum = {1'b0, m} + k;
        end
        if (sum >= SCAN_N) begin
            sum = sum - SCAN_N;
        end
        return sum[ANGLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/lagsp_sample_if.sv
`default_nettype none

interface lagsp_sample_if;
    logic                valid;
    logic                ready;
    lagsp_pkg::t_angle   sample_angle;
    lagsp_pkg::t_dist    sample_distance;

    modport source (output valid, output sample_angle, output sample_distance, input ready);
    modport sink   (input valid, input sample_angle, input sample_distance, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lagsp_result_if.sv
`default_nettype none

interface lagsp_result_if;
    logic                valid;
    logic                ready;
    lagsp_pkg::t_group   group_index;
    lagsp_pkg::t_angle   chosen_angle;
    lagsp_pkg::t_dist    chosen_distance;
    logic                last_of_run;

    modport source (output valid, output group_index, output chosen_angle,
                    output chosen_distance, output last_of_run, input ready);
    modport sink   (input valid, input group_index, input chosen_angle,
                    input chosen_distance, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lagsp_front.sv
`default_nettype none

module lagsp_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lagsp_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [lagsp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    lagsp_sample_if.sink                         i_sample,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output lagsp_pkg::t_cmd                      o_cmd,
    output lagsp_pkg::t_cfg                      o_cfg
);

    lagsp_pkg::t_cfg                          r_cfg;
    logic [lagsp_pkg::NUM_GROUPS-1:0]         g_hit;
    lagsp_pkg::t_rank                         g_rank [lagsp_pkg::NUM_GROUPS];
    logic                                     sel_found;
    lagsp_pkg::t_group                        sel_group;
    lagsp_pkg::t_rank                         sel_rank;
    logic                                     in_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.group_enable <= '0;
            r_cfg.main_angle   <= '0;
            r_cfg.min_distance <= lagsp_pkg::MIN_DIST_RESET;
        end else if (i_cfg_we) begin
            case (lagsp_pkg::t_reg_index'(i_cfg_index))
                lagsp_pkg::REG_GROUP_ENABLE: begin
                    r_cfg.group_enable <= i_cfg_data[lagsp_pkg::NUM_GROUPS-1:0];
                end
                lagsp_pkg::REG_MAIN_ANGLE_0: begin
                    r_cfg.main_angle[0] <= i_cfg_data[lagsp_pkg::ANGLE_W-1:0];
                end
                lagsp_pkg::REG_MAIN_ANGLE_1: begin
                    r_cfg.main_angle[1] <= i_cfg_data[lagsp_pkg::ANGLE_W-1:0];
                end
                lagsp_pkg::REG_MAIN_ANGLE_2: begin
                    r_cfg.main_angle[2] <= i_cfg_data[lagsp_pkg::ANGLE_W-1:0];
                end
                lagsp_pkg::REG_MAIN_ANGLE_3: begin
                    r_cfg.main_angle[3] <= i_cfg_data[lagsp_pkg::ANGLE_W-1:0];
                end
                lagsp_pkg::REG_MIN_DISTANCE: begin
                    r_cfg.min_distance <= i_cfg_data[lagsp_pkg::DIST_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // per group: lowest rank whose angle matches the sample
    always_comb begin
        for (int g = 0; g < lagsp_pkg::NUM_GROUPS; g++) begin
            g_hit[g]  = 1'b0;
            g_rank[g] = '0;
            for (int r = lagsp_pkg::NUM_SLOTS - 1; r >= 0; r--) begin
                if (lagsp_pkg::angle_of_rank(lagsp_pkg::main_of(r_cfg.main_angle[g]),
                        lagsp_pkg::RANK_W'(r)) == i_sample.sample_angle) begin
                    g_hit[g]  = 1'b1;
                    g_rank[g] = lagsp_pkg::RANK_W'(r);
                end
            end
        end
    end

    // overlapping groups go to the lowest-numbered one
    always_comb begin
        sel_found = 1'b0;
        sel_group = '0;
        sel_rank  = '0;
        for (int g = lagsp_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
            if (r_cfg.group_enable[g] && g_hit[g]) begin
                sel_found = 1'b1;
                sel_group = lagsp_pkg::GROUP_W'(g);
                sel_rank  = g_rank[g];
            end
        end
    end

    assign in_scan = {1'b0, i_sample.sample_angle} < lagsp_pkg::SCAN_N;

    assign i_sample.ready = !i_q_full;
    assign o_push         = i_sample.valid && !i_q_full;

    assign o_cmd.kind     = (sel_found && in_scan) ? lagsp_pkg::CMD_FILL : lagsp_pkg::CMD_FLUSH;
    assign o_cmd.group    = sel_group;
    assign o_cmd.rank     = sel_rank;
    assign o_cmd.dist_ok  = i_sample.sample_distance >= r_cfg.min_distance;
    assign o_cmd.distance = i_sample.sample_distance;

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/core/lagsp_cmd_fifo.sv
`default_nettype none

// depth of two or more
module lagsp_cmd_fifo #(
    parameter int DEPTH = lagsp_pkg::CMD_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lagsp_pkg::t_cmd   i_data,
    output logic              o_full,
    input  logic              i_pop,
    output lagsp_pkg::t_cmd   o_data,
    output logic              o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lagsp_pkg::t_cmd     r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr;
    logic [PTR_W-1:0]    r_rd;
    logic [CNT_W-1:0]    r_cnt;
    logic [PTR_W-1:0]    n_wr;
    logic [PTR_W-1:0]    n_rd;
    logic [CNT_W-1:0]    n_cnt;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CNT_W'(1);
            2'b01:   n_cnt = r_cnt - CNT_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];

endmodule

`default_nettype wire

>>> rtl/core/lagsp_back.sv
`default_nettype none

module lagsp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lagsp_pkg::t_cfg   i_cfg,
    input  logic              i_cmd_valid,
    input  lagsp_pkg::t_cmd   i_cmd,
    output logic              o_pop,
    lagsp_result_if.source    o_result
);

    typedef enum logic {
        ST_RUN,
        ST_WALK
    } t_state;

    typedef struct packed {
        lagsp_pkg::t_group group_index;
        lagsp_pkg::t_angle chosen_angle;
        lagsp_pkg::t_dist  chosen_distance;
        logic              last_of_run;
    } t_out;

    t_state                                   r_state,  n_state;
    logic [lagsp_pkg::NUM_SLOTS-1:0]          r_filled [lagsp_pkg::NUM_GROUPS];
    logic [lagsp_pkg::NUM_SLOTS-1:0]          n_filled [lagsp_pkg::NUM_GROUPS];
    lagsp_pkg::t_dist                         r_dist [lagsp_pkg::NUM_GROUPS][lagsp_pkg::NUM_SLOTS];
    lagsp_pkg::t_dist                         n_dist [lagsp_pkg::NUM_GROUPS][lagsp_pkg::NUM_SLOTS];
    logic [lagsp_pkg::NUM_GROUPS-1:0]         r_queued, n_queued;
    lagsp_pkg::t_group                        r_order [lagsp_pkg::NUM_GROUPS];
    lagsp_pkg::t_group                        n_order [lagsp_pkg::NUM_GROUPS];
    logic [lagsp_pkg::COUNT_W-1:0]            r_count,  n_count;
    lagsp_pkg::t_group                        r_idx,    n_idx;
    logic                                     r_out_valid, n_out_valid;
    t_out                                     r_out,    n_out;

    lagsp_pkg::t_group                        w_q;
    lagsp_pkg::t_rank                         w_rank;
    logic                                     w_last;
    logic                                     out_free;

    assign w_q      = r_order[r_idx];
    assign w_last   = (lagsp_pkg::COUNT_W'(r_idx) + lagsp_pkg::COUNT_W'(1)) == r_count;
    assign out_free = !r_out_valid || o_result.ready;

    // best filled rank of the group being flushed
    always_comb begin
        w_rank = '0;
        for (int r = lagsp_pkg::NUM_SLOTS - 1; r >= 0; r--) begin
            if (r_filled[w_q][r]) begin
                w_rank = lagsp_pkg::RANK_W'(r);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_filled    = r_filled;
        n_dist      = r_dist;
        n_queued    = r_queued;
        n_order     = r_order;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        case (r_state)
            ST_RUN: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == lagsp_pkg::CMD_FILL) begin
                        if (i_cmd.dist_ok && !r_filled[i_cmd.group][i_cmd.rank]) begin
                            n_filled[i_cmd.group][i_cmd.rank] = 1'b1;
                            n_dist[i_cmd.group][i_cmd.rank]   = i_cmd.distance;
                            // first fill puts the group in flush order
                            if (!r_queued[i_cmd.group]) begin
                                n_queued[i_cmd.group]                  = 1'b1;
                                n_order[r_count[lagsp_pkg::GROUP_W-1:0]] = i_cmd.group;
                                n_count = r_count + lagsp_pkg::COUNT_W'(1);
                            end
                        end
                    end else if (r_count != '0) begin
                        n_state = ST_WALK;
                        n_idx   = '0;
                    end
                end
            end
            ST_WALK: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.group_index     = w_q;
                    n_out.chosen_angle    = lagsp_pkg::angle_of_rank(
                        lagsp_pkg::main_of(i_cfg.main_angle[w_q]), w_rank);
                    n_out.chosen_distance = r_dist[w_q][w_rank];
                    n_out.last_of_run     = w_last;
                    n_filled[w_q]         = '0;
                    n_queued[w_q]         = 1'b0;
                    if (w_last) begin
                        n_count = '0;
                        n_state = ST_RUN;
                    end else begin
                        n_idx = r_idx + lagsp_pkg::GROUP_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_dist  <= n_dist;
        r_order <= n_order;
        r_idx   <= n_idx;
        r_out   <= n_out;
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_filled    <= '{default: '0};
            r_queued    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_filled    <= n_filled;
            r_queued    <= n_queued;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.group_index     = r_out.group_index;
    assign o_result.chosen_angle    = r_out.chosen_angle;
    assign o_result.chosen_distance = r_out.chosen_distance;
    assign o_result.last_of_run     = r_out.last_of_run;

endmodule

`default_nettype wire

>>> rtl/core/lidar_angle_group_sample_picker.sv
`default_nettype none

// Lidar angle-group sample picker. Each sample (angle, distance) is classified in the
// cycle it is accepted against the enabled groups (main angle, one step back, one step
// forward, lowest group wins) and placed as a fill or flush command in a short command
// queue of QUEUE_DEPTH entries; the sample port is ready whenever that queue has room.
// The back end executes one command at a time, taking the next once the previous one is
// done: a fill records an accepted distance in an empty slot of its group, and a flush
// emits one result per queued group while results are taken, so the pace is set by the
// back-end sequencer and the output register. The first result of a flush passes through
// the command queue, the walk state and the output register. A stalled output result
// holds the back end in its flush; samples enter only while the command queue has room.
// Configuration writes take effect at once and are meant to be issued while no sample is
// in flight; chosen_angle is built from the main angle in force when the group is flushed.
module lidar_angle_group_sample_picker #(
    parameter int QUEUE_DEPTH = lagsp_pkg::CMD_QUEUE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lagsp_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [lagsp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    lagsp_sample_if.sink                         i_sample,
    lagsp_result_if.source                       o_result
);

    logic              q_full;
    logic              q_empty;
    logic              q_push;
    logic              q_pop;
    lagsp_pkg::t_cmd   cmd_in;
    lagsp_pkg::t_cmd   cmd_out;
    lagsp_pkg::t_cfg   cfg;

    lagsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_sample),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (cmd_in),
        .o_cfg       (cfg)
    );

    lagsp_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (cmd_out),
        .o_empty (q_empty)
    );

    lagsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (!q_empty),
        .i_cmd       (cmd_out),
        .o_pop       (q_pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

>>> rtl/core/lagsp_checker.sv
`default_nettype none

`include "lidar_angle_group_sample_picker_defines.svh"

module lagsp_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  lagsp_pkg::t_group   i_group_index,
    input  lagsp_pkg::t_angle   i_chosen_angle,
    input  lagsp_pkg::t_dist    i_chosen_distance,
    input  logic                i_last_of_run
);

    localparam int PAYLOAD_W = lagsp_pkg::GROUP_W + lagsp_pkg::ANGLE_W + lagsp_pkg::DIST_W + 1;

    logic                 res_stall;
    logic                 res_more;
    logic                 angle_ok;
    logic [PAYLOAD_W-1:0] res_payload;

    assign res_stall   = i_res_valid && !i_res_ready;
    assign res_more    = i_res_valid && i_res_ready && !i_last_of_run;
    assign angle_ok    = {1'b0, i_chosen_angle} < lagsp_pkg::SCAN_N;
    assign res_payload = {i_group_index, i_chosen_angle, i_chosen_distance, i_last_of_run};

    // a stalled result holds its payload
    `LAGSP_ASSERT_NEXT(a_res_hold, i_clk, !i_rst_n, res_stall, i_res_valid && $stable(res_payload))

    // nothing comes out right after reset
    `LAGSP_ASSERT_NEXT(a_reset_idle, i_clk, 1'b0, !i_rst_n, !i_res_valid)

    `LAGSP_ASSERT_IMPL(a_angle_range, i_clk, !i_rst_n, i_res_valid, angle_ok)

    // consecutive results of one flush name different groups
    `LAGSP_ASSERT_NEXT(a_run_unique, i_clk, !i_rst_n, res_more, !i_res_valid || $changed(i_group_index))

endmodule

bind lidar_angle_group_sample_picker lagsp_checker u_lagsp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_res_valid       (o_result.valid),
    .i_res_ready       (o_result.ready),
    .i_group_index     (o_result.group_index),
    .i_chosen_angle    (o_result.chosen_angle),
    .i_chosen_distance (o_result.chosen_distance),
    .i_last_of_run     (o_result.last_of_run)
);

`default_nettype wire
